FILE: rtl/kcl_pkg.sv
// Package for the keypad code lock: status codes, result record and defaults.
// Used by every module in rtl/; depends on nothing.
package kcl_pkg;

  localparam int unsigned CODE_LEN_DEF = 6;
  localparam logic [7:0] NO_KEY = 8'hff;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_FIRST_DONE = 3'd1,
    ST_ENROLLED   = 3'd2,
    ST_DIFFER     = 3'd3,
    ST_UNLOCK     = 3'd4,
    ST_WRONG      = 3'd5
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [3:0] entered_count;
  } kcl_result_t;

endpackage

FILE: rtl/kcl_in_reg.sv
// Input register of the keypad code lock: holds one key transfer.
// Depends on kcl_pkg.
module kcl_in_reg import kcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] key_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] key_o
);

  logic       valid_q, valid_d;
  logic [7:0] key_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      key_q <= key_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

FILE: rtl/kcl_core.sv
// Enrollment and unlock logic of the keypad code lock: key stores, entry
// counter and code compares. Depends on kcl_pkg.
module kcl_core import kcl_pkg::*; #(
  parameter int unsigned CodeLen = CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  key_i,
  output kcl_result_t result_o
);

  localparam int unsigned IdxW = $clog2(2 * CodeLen + 1);
  localparam int unsigned PosW = (CodeLen > 1) ? $clog2(CodeLen) : 1;
  localparam logic [IdxW-1:0] LenIdx  = IdxW'(CodeLen);
  localparam logic [IdxW-1:0] Len2Idx = IdxW'(2 * CodeLen);
  localparam logic [IdxW-1:0] OneIdx  = IdxW'(1);

  logic [7:0] first_q  [CodeLen];
  logic [7:0] second_q [CodeLen];
  logic [7:0] stored_q [CodeLen];

  logic            enrolled_q, enrolled_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            wr_first, wr_second, copy_code;
  logic [PosW-1:0] wr_pos;
  logic [IdxW-1:0] idx_sub, eff_idx, idx_inc;
  logic            enroll_eq, unlock_eq;
  logic [IdxW+3:0] count_wide;
  status_e         status;

  // Compare with the current key standing in the last position.
  always_comb begin
    enroll_eq = 1'b1;
    unlock_eq = 1'b1;
    for (int unsigned i = 0; i < CodeLen; i++) begin
      if (i == CodeLen - 1) begin
        enroll_eq = enroll_eq && (first_q[i] == key_i);
        unlock_eq = unlock_eq && (key_i == stored_q[i]);
      end else begin
        enroll_eq = enroll_eq && (first_q[i] == second_q[i]);
        unlock_eq = unlock_eq && (first_q[i] == stored_q[i]);
      end
    end
  end

  always_comb begin
    idx_sub    = idx_q - LenIdx;
    eff_idx    = (idx_q >= LenIdx) ? '0 : idx_q;
    idx_inc    = '0;
    wr_first   = 1'b0;
    wr_second  = 1'b0;
    copy_code  = 1'b0;
    wr_pos     = idx_q[PosW-1:0];
    enrolled_d = enrolled_q;
    idx_d      = idx_q;
    status     = ST_IDLE;
    if (fire_i && key_i != NO_KEY) begin
      if (!enrolled_q) begin
        if (idx_q < LenIdx) begin
          wr_first = 1'b1;
          idx_d    = idx_q + OneIdx;
          if (idx_d == LenIdx) begin
            status = ST_FIRST_DONE;
          end
        end else if (idx_q < Len2Idx) begin
          wr_second = 1'b1;
          wr_pos    = idx_sub[PosW-1:0];
          idx_d     = idx_q + OneIdx;
          if (idx_d == Len2Idx) begin
            if (enroll_eq) begin
              copy_code  = 1'b1;
              enrolled_d = 1'b1;
              status     = ST_ENROLLED;
            end else begin
              status = ST_DIFFER;
            end
            idx_d = '0;
          end
        end else begin
          idx_d = '0;
        end
      end else begin
        wr_first = 1'b1;
        wr_pos   = eff_idx[PosW-1:0];
        idx_inc  = eff_idx + OneIdx;
        idx_d    = idx_inc;
        if (idx_inc == LenIdx) begin
          status = unlock_eq ? ST_UNLOCK : ST_WRONG;
          idx_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enrolled_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      enrolled_q <= enrolled_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      first_q[wr_pos] <= key_i;
    end
    if (wr_second) begin
      second_q[wr_pos] <= key_i;
    end
    if (copy_code) begin
      stored_q <= first_q;
    end
  end

  assign count_wide             = {4'b0000, idx_d};
  assign result_o.status        = status;
  assign result_o.entered_count = count_wide[3:0];

endmodule

FILE: rtl/kcl_out_reg.sv
// Result register of the keypad code lock: holds one result until transfer.
// Depends on kcl_pkg.
module kcl_out_reg import kcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  kcl_result_t result_i,
  input  logic        ready_i,
  output logic        advance_o,
  output logic        valid_o,
  output kcl_result_t result_o
);

  logic        valid_q, valid_d;
  kcl_result_t result_q;

  assign advance_o = !valid_q || ready_i;
  assign valid_d   = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: rtl/keypad_code_lock_unit.sv
// Keypad code lock: one key code in per transfer, one status result out per
// transfer. A key code of 0xff means no key: nothing changes and the result
// reports idle with the current count. Until a code is enrolled the lock takes
// a first entry of CODE_LEN keys, then a second one; if they match the code is
// stored, otherwise both are dropped. Once enrolled, every CODE_LEN keys give
// unlock or wrong code and counting starts over. Each key is held in an input
// register, goes through the compare and counter logic, and lands in a result
// register that presents its result on the master side, so the block takes one
// key every clock unless both stages are full and the master side stalls. The
// input register keeps accepting while a result waits, until both stages are
// full.
// Depends on kcl_pkg, kcl_in_reg, kcl_core and kcl_out_reg.
module keypad_code_lock_unit import kcl_pkg::*; #(
  parameter int unsigned CODE_LEN = CODE_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] key_code
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [2:0] status, [6:3] entered_count, [7] zero
);

  logic        in_valid;
  logic [7:0]  in_key;
  logic        advance;
  logic        fire;
  kcl_result_t core_result;
  kcl_result_t out_result;

  // Hold the incoming key until the result stage can take its outcome.
  kcl_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .key_i     (s_axis_tdata_i),
    .advance_i (advance),
    .ready_o   (s_axis_tready_o),
    .valid_o   (in_valid),
    .key_o     (in_key)
  );

  // Advance the lock state only when the result register has room.
  assign fire = in_valid && advance;

  kcl_core #(
    .CodeLen (CODE_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .key_i    (in_key),
    .result_o (core_result)
  );

  kcl_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .result_i  (core_result),
    .ready_i   (m_axis_tready_i),
    .advance_o (advance),
    .valid_o   (m_axis_tvalid_o),
    .result_o  (out_result)
  );

  assign m_axis_tdata_o = {1'b0, out_result.entered_count, out_result.status};

  // A finished sequence always leaves the counter at zero.
  a_final_count_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (core_result.status == ST_ENROLLED || core_result.status == ST_DIFFER ||
              core_result.status == ST_UNLOCK || core_result.status == ST_WRONG))
    |-> core_result.entered_count == 4'd0)
    else $error("finished sequence left a nonzero count");

  // The first entry completes exactly at CODE_LEN keys.
  a_first_done_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && core_result.status == ST_FIRST_DONE)
    |-> core_result.entered_count == 4'(CODE_LEN))
    else $error("first entry done at wrong count");

  // Input stalls only when both stages hold an item and the sink is stalled.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without back pressure");

  // A processed key always lands in the result register.
  a_fire_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid_o)
    else $error("processed key produced no result");

endmodule
